// ===== design/brsv_pkg.sv =====
// Package for the bitmap rank sparse vector core.
// Holds the storage geometry, the request and status codes and the helper
// functions for popcount and value checks. It depends on nothing else.
`default_nettype none

package brsv_pkg;

	// Storage geometry.
	localparam int unsigned MAX_LENGTH   = 1024;
	localparam int unsigned WORD_BITS    = 64;
	localparam int unsigned BITMAP_WORDS = (MAX_LENGTH + WORD_BITS - 1) / WORD_BITS;

	// Field and counter widths.
	localparam int unsigned OP_W     = 2;
	localparam int unsigned IDX_W    = 10;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned CNT_W    = 11;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PACK_AW  = $clog2(MAX_LENGTH);
	localparam int unsigned WORD_AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int unsigned BIT_W    = $clog2(WORD_BITS);
	localparam int unsigned PC_W     = $clog2(WORD_BITS + 1);
	localparam int unsigned LANE_W   = 4;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT      = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP      = 2'd1;
	localparam logic [OP_W-1:0] OP_READ_PACKED = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE        = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE        = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_PRESENT      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_POSITIVE = 2'd3;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_LENGTH);

	// Population count of one bitmap word: eight-bit lanes, then a sum of lanes.
	function automatic logic [PC_W-1:0] popcount_word(input logic [WORD_BITS-1:0] w);
		logic [LANE_W-1:0] lane_cnt [WORD_BITS/8];
		logic [PC_W-1:0]   total;
		for (int b = 0; b < WORD_BITS / 8; b++) begin
			lane_cnt[b] = '0;
			for (int k = 0; k < 8; k++) begin
				lane_cnt[b] = lane_cnt[b] + LANE_W'(w[8*b+k]);
			end
		end
		total = '0;
		for (int b = 0; b < WORD_BITS / 8; b++) begin
			total = total + PC_W'(lane_cnt[b]);
		end
		return total;
	endfunction

	// A single-precision pattern is positive when the sign is clear, it is not
	// zero and it is not a NaN.
	function automatic logic is_positive(input logic [VAL_W-1:0] v);
		logic is_nan;
		is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
		return !v[31] && (v != '0) && !is_nan;
	endfunction

endpackage

`default_nettype wire

// ===== design/brsv_if.sv =====
// Request and response channel interfaces for the sparse vector core.
// Depends on brsv_pkg for the field widths.
`default_nettype none

interface brsv_req_if;
	logic                         valid;
	logic                         ready;
	logic [brsv_pkg::OP_W-1:0]    operation;
	logic [brsv_pkg::IDX_W-1:0]   index;
	logic [brsv_pkg::VAL_W-1:0]   value_in;

	modport source (output valid, output operation, output index, output value_in,
		input ready);
	modport sink (input valid, input operation, input index, input value_in,
		output ready);
endinterface

interface brsv_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [brsv_pkg::VAL_W-1:0]      value_out;
	logic                            present;
	logic [brsv_pkg::CNT_W-1:0]      entry_count;
	logic [brsv_pkg::STATUS_W-1:0]   status;

	modport source (output valid, output value_out, output present, output entry_count,
		output status, input ready);
	modport sink (input valid, input value_out, input present, input entry_count,
		input status, output ready);
endinterface

`default_nettype wire

// ===== design/brsv_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for both the presence bitmap and the packed values.
`default_nettype none

module brsv_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/bitmap_rank_sparse_vector_core.sv =====
// Top level of the bitmap rank sparse vector core.
// Depends on brsv_pkg, the channel interfaces in brsv_if and the RAM brsv_ram.
//
// Usage. Requests arrive on the req channel (operation, index, value_in) and
// are taken at a clock edge where valid and ready are both high. Each request
// yields exactly one response on the rsp channel (value_out, present,
// entry_count, status). The vector length register is written through cfg_we and
// cfg_data; the user must write it only while the block is idle, unchecked by it.
//
// The block handles one request at a time. A lookup or insert walks the presence
// bitmap RAM one 64-bit word per cycle up to the word holding the index, summing
// popcounts for the packed rank. An insert then moves every later packed entry up
// one place, top entry first, before it stores the new value. A read by packed
// position reads the value RAM directly; an unused code or an index out of range
// goes straight to the response. The response becomes valid in the same cycle as
// the block can take the next request.
//
// The response sits in an output register; a new request is taken while it
// waits, and a finished result is held back until the register is free, so a
// stalled receiver loses nothing. Reset clears the bitmap valid bits, the entry
// count and the control state and sets the length to its maximum.
`default_nettype none

module bitmap_rank_sparse_vector_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	brsv_req_if.sink                       req,
	brsv_rsp_if.source                     rsp,
	input  wire logic                      cfg_we,
	input  wire logic [brsv_pkg::CNT_W-1:0] cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_SCAN      = 9'b000000010,
		ST_RANK      = 9'b000000100,
		ST_DECIDE    = 9'b000001000,
		ST_SHIFT     = 9'b000010000,
		ST_SHIFT_END = 9'b000100000,
		ST_WRVAL     = 9'b001000000,
		ST_PREAD     = 9'b010000000,
		ST_RESP      = 9'b100000000
	} state_t;

	state_t state_q;

	// Request held for the duration of its work.
	logic [brsv_pkg::OP_W-1:0]    op_q;
	logic [brsv_pkg::IDX_W-1:0]   idx_q;
	logic [brsv_pkg::VAL_W-1:0]   val_q;

	logic [brsv_pkg::CNT_W-1:0]   vlen_q;
	logic [brsv_pkg::CNT_W-1:0]   count_q;

	// Rank scan.
	logic [brsv_pkg::WORD_AW-1:0]   scan_w_q;
	logic                           scan_v_s1;
	logic                           scan_last_s1;
	logic [brsv_pkg::WORD_AW-1:0]   scan_w_s1;
	logic [brsv_pkg::CNT_W-1:0]     rank_q;
	logic [brsv_pkg::WORD_BITS-1:0] word_q;

	// Shift of the packed entries.
	logic [brsv_pkg::PACK_AW-1:0] shift_p_q;
	logic                         sh_v_s1;
	logic [brsv_pkg::PACK_AW-1:0] sh_addr_s1;

	// Result being assembled.
	logic [brsv_pkg::VAL_W-1:0]    res_value_q;
	logic                          res_present_q;
	logic [brsv_pkg::STATUS_W-1:0] res_status_q;

	// Output register.
	logic                          out_valid_q;
	logic [brsv_pkg::VAL_W-1:0]    out_value_q;
	logic                          out_present_q;
	logic [brsv_pkg::CNT_W-1:0]    out_count_q;
	logic [brsv_pkg::STATUS_W-1:0] out_status_q;

	// Bitmap words that have never been written read as zero.
	logic [brsv_pkg::BITMAP_WORDS-1:0] bm_valid_q;

	logic                            bm_we;
	logic [brsv_pkg::WORD_AW-1:0]    bm_waddr;
	logic [brsv_pkg::WORD_BITS-1:0]  bm_wdata;
	logic [brsv_pkg::WORD_BITS-1:0]  bm_rdata;
	logic [brsv_pkg::WORD_BITS-1:0]  bm_word;

	logic                            pv_we;
	logic [brsv_pkg::PACK_AW-1:0]    pv_waddr;
	logic [brsv_pkg::VAL_W-1:0]      pv_wdata;
	logic [brsv_pkg::PACK_AW-1:0]    pv_raddr;
	logic [brsv_pkg::VAL_W-1:0]      pv_rdata;

	logic                            accept;
	logic                            out_load;
	logic [brsv_pkg::CNT_W-1:0]      limit;
	logic                            in_range;
	logic [brsv_pkg::WORD_AW-1:0]    idx_word;
	logic [brsv_pkg::BIT_W-1:0]      idx_bit;
	logic [brsv_pkg::WORD_BITS-1:0]  low_mask;
	logic [brsv_pkg::WORD_BITS-1:0]  scan_bits;
	logic                            bit_now;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

	// The limit is the length register clamped to the storage size.
	assign limit    = (vlen_q > brsv_pkg::MAX_COUNT) ? brsv_pkg::MAX_COUNT : vlen_q;
	assign in_range = {1'b0, req.index} < limit;

	assign idx_word  = idx_q[brsv_pkg::IDX_W-1 -: brsv_pkg::WORD_AW];
	assign idx_bit   = idx_q[brsv_pkg::BIT_W-1:0];
	assign low_mask  = ~({brsv_pkg::WORD_BITS{1'b1}} << idx_bit);
	assign bm_word   = bm_valid_q[scan_w_s1] ? bm_rdata : '0;
	assign scan_bits = scan_last_s1 ? (bm_word & low_mask) : bm_word;
	assign bit_now   = word_q[idx_bit];

	// Bitmap RAM: read by the scan, written once at the end of an insert.
	assign bm_we    = (state_q == ST_WRVAL);
	assign bm_waddr = idx_word;
	assign bm_wdata = word_q | ~({brsv_pkg::WORD_BITS{1'b1}} << 1 << idx_bit)
		& ({brsv_pkg::WORD_BITS{1'b1}} << idx_bit);

	brsv_ram #(
		.WIDTH (brsv_pkg::WORD_BITS),
		.DEPTH (brsv_pkg::BITMAP_WORDS)
	) u_bitmap_ram (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (scan_w_q),
		.rdata (bm_rdata)
	);

	// Packed value RAM. During the shift the read runs two entries below the
	// write of the previous read's data, so the two never touch one entry.
	always_comb begin
		pv_we    = 1'b0;
		pv_waddr = sh_addr_s1 + brsv_pkg::PACK_AW'(1);
		pv_wdata = pv_rdata;
		if (sh_v_s1) begin
			pv_we = 1'b1;
		end else if (state_q == ST_WRVAL) begin
			pv_we    = 1'b1;
			pv_waddr = rank_q[brsv_pkg::PACK_AW-1:0];
			pv_wdata = val_q;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:   pv_raddr = req.index[brsv_pkg::PACK_AW-1:0];
			ST_DECIDE: pv_raddr = rank_q[brsv_pkg::PACK_AW-1:0];
			default:   pv_raddr = shift_p_q;
		endcase
	end

	brsv_ram #(
		.WIDTH (brsv_pkg::VAL_W),
		.DEPTH (brsv_pkg::MAX_LENGTH)
	) u_value_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (pv_raddr),
		.rdata (pv_rdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= brsv_pkg::MAX_COUNT;
		end else if (cfg_we) begin
			vlen_q <= cfg_data;
		end
	end

	// Sequencer and stored state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			bm_valid_q   <= '0;
			scan_v_s1    <= 1'b0;
			scan_last_s1 <= 1'b0;
			sh_v_s1      <= 1'b0;
		end else begin
			scan_v_s1 <= 1'b0;
			sh_v_s1   <= 1'b0;

			// The scan accumulates one word a cycle, in the cycle after the read.
			if (scan_v_s1) begin
				rank_q <= rank_q + brsv_pkg::CNT_W'(brsv_pkg::popcount_word(scan_bits));
				if (scan_last_s1) begin
					word_q <= bm_word;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q          <= req.operation;
						idx_q         <= req.index;
						val_q         <= req.value_in;
						res_value_q   <= '0;
						res_present_q <= 1'b0;
						res_status_q  <= brsv_pkg::STATUS_OK;
						scan_w_q      <= '0;
						rank_q        <= '0;
						unique case (req.operation) inside
							brsv_pkg::OP_INSERT, brsv_pkg::OP_LOOKUP: begin
								if (in_range) begin
									state_q <= ST_SCAN;
								end else begin
									res_status_q <= brsv_pkg::STATUS_RANGE;
									state_q      <= ST_RESP;
								end
							end
							brsv_pkg::OP_READ_PACKED: begin
								if ({1'b0, req.index} >= count_q) begin
									res_status_q <= brsv_pkg::STATUS_RANGE;
									state_q      <= ST_RESP;
								end else begin
									res_present_q <= 1'b1;
									state_q       <= ST_PREAD;
								end
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_v_s1    <= 1'b1;
					scan_w_s1    <= scan_w_q;
					scan_last_s1 <= (scan_w_q == idx_word);
					if (scan_w_q == idx_word) begin
						state_q <= ST_RANK;
					end else begin
						scan_w_q <= scan_w_q + brsv_pkg::WORD_AW'(1);
					end
				end
				ST_RANK: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (op_q == brsv_pkg::OP_LOOKUP) begin
						res_present_q <= bit_now;
						state_q       <= bit_now ? ST_PREAD : ST_RESP;
					end else if (!brsv_pkg::is_positive(val_q)) begin
						res_status_q  <= brsv_pkg::STATUS_NOT_POSITIVE;
						res_present_q <= bit_now;
						state_q       <= ST_RESP;
					end else if (bit_now) begin
						res_status_q  <= brsv_pkg::STATUS_PRESENT;
						res_present_q <= 1'b1;
						state_q       <= ST_RESP;
					end else begin
						res_present_q <= 1'b1;
						if (count_q < brsv_pkg::MAX_COUNT && rank_q <= count_q) begin
							shift_p_q <= brsv_pkg::PACK_AW'(count_q - brsv_pkg::CNT_W'(1));
							state_q   <= (count_q > rank_q) ? ST_SHIFT : ST_WRVAL;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SHIFT: begin
					sh_v_s1    <= 1'b1;
					sh_addr_s1 <= shift_p_q;
					if (shift_p_q == rank_q[brsv_pkg::PACK_AW-1:0]) begin
						state_q <= ST_SHIFT_END;
					end else begin
						shift_p_q <= shift_p_q - brsv_pkg::PACK_AW'(1);
					end
				end
				ST_SHIFT_END: begin
					state_q <= ST_WRVAL;
				end
				ST_WRVAL: begin
					count_q              <= count_q + brsv_pkg::CNT_W'(1);
					bm_valid_q[idx_word] <= 1'b1;
					state_q              <= ST_RESP;
				end
				ST_PREAD: begin
					res_value_q <= pv_rdata;
					state_q     <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q   <= res_value_q;
			out_present_q <= res_present_q;
			out_count_q   <= count_q;
			out_status_q  <= res_status_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.value_out   = out_value_q;
	assign rsp.present     = out_present_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.status      = out_status_q;

	// The entry count never passes the storage size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= brsv_pkg::MAX_COUNT)
		else $error("entry count exceeds storage size");

	// The shift never reads below the insertion rank.
	a_shift_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (shift_p_q >= rank_q[brsv_pkg::PACK_AW-1:0]))
		else $error("shift pointer below insertion rank");

	// Storing the new value adds exactly one entry.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRVAL) |=> (count_q == $past(count_q) + brsv_pkg::CNT_W'(1)))
		else $error("insert did not add one entry");

	// An unused operation code goes straight to the response.
	a_none_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == brsv_pkg::OP_NONE) |=> (state_q == ST_RESP))
		else $error("unused operation code did not respond at once");

endmodule

`default_nettype wire

// ===== sim/bitmap_rank_sparse_vector_core_checker.sv =====
// Response checker for the bitmap rank sparse vector core.
// Watches the request and response channels and the length register port, keeps a
// shadow copy of the store and compares every response. Depends on brsv_pkg and brsv_if.

module bitmap_rank_sparse_vector_core_checker
	import brsv_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	brsv_req_if                   req,
	brsv_rsp_if                   rsp,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding,
	output int                    replies_checked,
	output int                    entries_held
);

	typedef struct packed {
		logic [VAL_W-1:0]    value;
		logic                present;
		logic [CNT_W-1:0]    count;
		logic [STATUS_W-1:0] status;
	} vector_reply_t;

	logic [MAX_LENGTH-1:0] shadow_bitmap;
	logic [VAL_W-1:0]      shadow_values [MAX_LENGTH];
	logic [CNT_W-1:0]      shadow_count;
	logic [CNT_W-1:0]      shadow_length;
	vector_reply_t         awaited_replies [$];
	vector_reply_t         oldest;
	vector_reply_t         fresh;

	task automatic clear_shadow();
		shadow_bitmap = '0;
		shadow_count = '0;
		shadow_length = MAX_COUNT;
		awaited_replies.delete();
		fail_count = 0;
		outstanding = 0;
		replies_checked = 0;
		entries_held = 0;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		fail_count++;
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, seen,
			wanted);
	endtask

	// Sign clear, some bit set, and not a NaN (exponent all ones with a mantissa).
	function automatic logic counts_as_positive(input logic [VAL_W-1:0] v);
		logic nan;
		nan = (&v[30:23]) && (|v[22:0]);
		return !v[31] && (|v[30:0]) && !nan;
	endfunction

	// Number of present entries at logical indices below idx.
	function automatic int unsigned rank_of(input int unsigned idx);
		int unsigned r;
		r = 0;
		for (int i = 0; i < idx; i++) begin
			r += shadow_bitmap[i];
		end
		return r;
	endfunction

	// Applies one request to the shadow store and returns the response it must give.
	function automatic vector_reply_t apply_request(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		vector_reply_t rep;
		int unsigned   limit;
		int unsigned   pos;
		rep = '0;
		rep.status = STATUS_OK;
		limit = (shadow_length < MAX_LENGTH) ? shadow_length : MAX_LENGTH;
		case (op)
			OP_INSERT: begin
				if (idx >= limit) begin
					rep.status = STATUS_RANGE;
				end else if (!counts_as_positive(val)) begin
					rep.status = STATUS_NOT_POSITIVE;
					rep.present = shadow_bitmap[idx];
				end else if (shadow_bitmap[idx]) begin
					rep.status = STATUS_PRESENT;
					rep.present = 1'b1;
				end else begin
					pos = rank_of(idx);
					if (shadow_count < MAX_COUNT && pos <= shadow_count) begin
						for (int i = int'(shadow_count); i > int'(pos); i--) begin
							shadow_values[i] = shadow_values[i-1];
						end
						shadow_values[pos] = val;
						shadow_count = shadow_count + 1'b1;
						shadow_bitmap[idx] = 1'b1;
					end
					rep.present = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (idx >= limit) begin
					rep.status = STATUS_RANGE;
				end else if (shadow_bitmap[idx]) begin
					rep.present = 1'b1;
					rep.value = shadow_values[rank_of(idx)];
				end
			end
			OP_READ_PACKED: begin
				if (idx >= shadow_count) begin
					rep.status = STATUS_RANGE;
				end else begin
					rep.present = 1'b1;
					rep.value = shadow_values[idx];
				end
			end
			default: begin
			end
		endcase
		rep.count = shadow_count;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_shadow();
		end else begin
			if (cfg_we) begin
				shadow_length = cfg_data;
			end
			// A response can never belong to a request taken at the same edge.
			if (rsp.valid && rsp.ready) begin
				if (awaited_replies.size() == 0) begin
					report_mismatch("response with none awaited", rsp.value_out, '0);
				end else begin
					oldest = awaited_replies.pop_front();
					if (rsp.value_out !== oldest.value)
						report_mismatch("value_out", rsp.value_out, oldest.value);
					if (rsp.present !== oldest.present)
						report_mismatch("present", rsp.present, oldest.present);
					if (rsp.entry_count !== oldest.count)
						report_mismatch("entry_count", rsp.entry_count, oldest.count);
					if (rsp.status !== oldest.status)
						report_mismatch("status", rsp.status, oldest.status);
					replies_checked++;
				end
			end
			if (req.valid && req.ready) begin
				fresh = apply_request(req.operation, req.index, req.value_in);
				awaited_replies.insert(awaited_replies.size(), fresh);
			end
			outstanding = awaited_replies.size();
			entries_held = shadow_count;
		end
	end

endmodule

// ===== sim/bitmap_rank_sparse_vector_core_tb.sv =====
// Top of the testbench for the bitmap rank sparse vector core.
// Makes requests, response stalls and length register writes, and gives the verdict;
// checking is done by bitmap_rank_sparse_vector_core_checker. Depends on brsv_pkg, brsv_if.

module bitmap_rank_sparse_vector_core_tb;
	import brsv_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int MAX_GAP         = 13;
	// The receiver's long hold-off, long enough for the block to fill and stall its input.
	localparam int HOLD_OFF_CYCLES = 300;
	// The slowest request is an insert near index 0 into a nearly full store: a walk to its
	// bitmap word plus a shift of every packed entry.
	localparam int SETTLE_CYCLES   = 1200;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_data;

	brsv_req_if req ();
	brsv_rsp_if rsp ();

	int fail_count;
	int outstanding;
	int replies_checked;
	int entries_held;

	int requests_sent = 0;
	int lengths_used = 1;
	// Both sides stop idling during a quiet stretch; the sender also goes flat out while
	// eager_left counts down, which is how the long receiver hold-off builds up pressure.
	bit quiet_stretch = 1'b0;
	int stretch_left = 0;
	int eager_left = 0;
	bit hold_off_wanted = 1'b0;

	always #(CLK_HALF) clk = ~clk;

	bitmap_rank_sparse_vector_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	bitmap_rank_sparse_vector_core_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.replies_checked (replies_checked),
		.entries_held    (entries_held)
	);

	// A positive single-precision pattern: mostly random finite values, now and then a
	// subnormal or positive infinity.
	function automatic logic [VAL_W-1:0] positive_pattern();
		logic [7:0]  expo;
		logic [22:0] mant;
		expo = 8'($urandom_range(0, 254));
		mant = 23'($urandom);
		if ($urandom_range(0, 15) == 0) return 32'h7F80_0000;
		if ($urandom_range(0, 15) == 0) expo = 8'd0;
		if (expo == 8'd0 && mant == 23'd0) mant = 23'd1;
		return {1'b0, expo, mant};
	endfunction

	// A pattern that an insert must refuse: zero, anything negative, or a NaN.
	function automatic logic [VAL_W-1:0] rejected_pattern();
		int unsigned kind;
		logic [22:0] mant;
		kind = $urandom_range(0, 2);
		mant = 23'($urandom);
		if (mant == 23'd0) mant = 23'd1;
		if (kind == 0) return '0;
		if (kind == 1) return {1'b1, 31'($urandom)};
		return {1'($urandom), 8'hFF, mant};
	endfunction

	// Offers one request and returns at the edge where it is taken. Valid is only lowered
	// when a gap follows, so it is never dropped and raised in the same time step.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		int gap;
		if (stretch_left == 0) begin
			stretch_left = 32;
			quiet_stretch = ($urandom_range(0, 3) == 0);
		end
		stretch_left--;
		gap = (quiet_stretch || eager_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
		if (eager_left > 0) eager_left--;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.index <= idx;
		req.value_in <= val;
		do @(posedge clk); while (req.ready !== 1'b1);
		requests_sent++;
	endtask

	// One random request. Most are well formed (positive inserts and lookups inside the
	// current length, reads near the filled part of the packed store); the rest are
	// refused values, indices anywhere in the field and the unused operation code.
	task automatic random_request(input int unsigned span);
		int unsigned      pick;
		int unsigned      top_pos;
		logic [IDX_W-1:0] idx;
		pick = $urandom_range(0, 99);
		idx = (span == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, span - 1));
		top_pos = (entries_held < MAX_LENGTH - 1) ? entries_held + 1 : MAX_LENGTH - 1;
		if (pick < 55)
			send_request(OP_INSERT, idx, positive_pattern());
		else if (pick < 75)
			send_request(OP_LOOKUP, idx, $urandom);
		else if (pick < 85)
			send_request(OP_READ_PACKED, IDX_W'($urandom_range(0, top_pos)), $urandom);
		else if (pick < 92)
			send_request(OP_INSERT, idx, rejected_pattern());
		else if (pick < 97)
			send_request(OP_W'($urandom_range(0, 3)), IDX_W'($urandom), $urandom);
		else
			send_request(OP_NONE, IDX_W'($urandom), $urandom);
	endtask

	// Drops valid and waits, with a bound, until every awaited response has come back.
	task automatic settle();
		int guard;
		req.valid <= 1'b0;
		guard = 0;
		@(posedge clk);
		while (outstanding != 0 && guard < 4 * SETTLE_CYCLES) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// The length register is only written once the block has gone idle.
	task automatic set_length(input logic [CNT_W-1:0] len);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		lengths_used++;
	endtask

	// Receiver: a random stall before each response, quiet stretches with none, and one
	// long hold-off counted here while the sender keeps offering requests.
	initial begin : response_taker
		int stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_wanted) begin
				hold_off_wanted = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			stall = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
		end
	end

	initial begin : stimulus
		req.valid <= 1'b0;
		req.operation <= OP_NONE;
		req.index <= '0;
		req.value_in <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset length. An empty store first, then inserts at both
		// ends of the index range with the extreme positive patterns, then every way an
		// insert can be refused at this length, and reads of what was stored.
		send_request(OP_LOOKUP, 10'd0, 32'h0000_0000);
		send_request(OP_READ_PACKED, 10'd0, 32'hFFFF_FFFF);
		send_request(OP_NONE, 10'd1023, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 10'd1023, 32'h7F80_0000);
		send_request(OP_INSERT, 10'd0, 32'h0000_0001);
		send_request(OP_INSERT, 10'd512, 32'h7F7F_FFFF);
		send_request(OP_INSERT, 10'd0, 32'h3F80_0000);
		send_request(OP_INSERT, 10'd5, 32'h0000_0000);
		send_request(OP_INSERT, 10'd0, 32'h8000_0000);
		send_request(OP_INSERT, 10'd5, 32'h7F80_0001);
		send_request(OP_INSERT, 10'd5, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 10'd5, 32'h7FFF_FFFF);
		send_request(OP_INSERT, 10'd1, 32'h2AAA_AAAA);
		send_request(OP_INSERT, 10'd2, 32'h5555_5555);
		send_request(OP_LOOKUP, 10'd0, 32'h0000_0000);
		send_request(OP_LOOKUP, 10'd512, 32'h0000_0000);
		send_request(OP_LOOKUP, 10'd1023, 32'h0000_0000);
		send_request(OP_LOOKUP, 10'd5, 32'h0000_0000);
		send_request(OP_READ_PACKED, 10'd0, 32'h0000_0000);
		// Five entries are stored, so position four is the last and five is just past it.
		send_request(OP_READ_PACKED, 10'd4, 32'h0000_0000);
		send_request(OP_READ_PACKED, 10'd5, 32'h0000_0000);
		send_request(OP_READ_PACKED, 10'd1023, 32'h0000_0000);
		send_request(OP_NONE, 10'd0, 32'h0000_0000);

		// Shrinking the length leaves the stored entries in place: the range check wins
		// over the value check, and entries above the length stay readable by position.
		set_length(11'd1);
		send_request(OP_INSERT, 10'd700, 32'h0000_0000);
		send_request(OP_LOOKUP, 10'd1023, 32'h0000_0000);
		send_request(OP_READ_PACKED, IDX_W'(entries_held - 1), 32'h0000_0000);
		repeat (40) random_request(1);

		// A length of zero refuses every logical index.
		set_length(11'd0);
		repeat (25) random_request(0);

		// Short length with the receiver holding off while the sender runs flat out.
		set_length(11'd64);
		hold_off_wanted = 1'b1;
		eager_left = 40;
		repeat (150) random_request(64);

		// A length above the maximum is clamped, so the whole index range is open.
		set_length(11'd2047);
		repeat (150) random_request(MAX_LENGTH);

		set_length(11'd300);
		repeat (100) random_request(300);

		// Back to the full length and fill the store in ascending order, which keeps the
		// shifts short, with random requests mixed in; the store ends completely full.
		set_length(MAX_COUNT);
		for (int i = 0; i < MAX_LENGTH; i++) begin
			send_request(OP_INSERT, IDX_W'(i), positive_pattern());
			if ($urandom_range(0, 4) == 0) random_request(MAX_LENGTH);
		end
		repeat (30) random_request(MAX_LENGTH);

		// Wait for the last responses, then long enough for the slowest request to show
		// up as a stray response if the block produced one.
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests under %0d length settings; %0d responses checked.",
			requests_sent, lengths_used, replies_checked);
		$display("The store ended with %0d entries.", entries_held);
		if (outstanding != 0) begin
			$display("%0d expected responses never arrived.", outstanding);
		end
		if (fail_count == 0 && outstanding == 0) begin
			$display("[bitmap_rank_sparse_vector_core] OK");
		end else begin
			$display("[bitmap_rank_sparse_vector_core] ERROR");
		end
		$finish;
	end

	// Several times the slowest correct run: every request an insert with the longest
	// shift, behind the longest gap and the longest stall.
	initial begin : watchdog
		#100_000_000;
		$display("Timed out with %0d responses still awaited.", outstanding);
		$display("[bitmap_rank_sparse_vector_core] ERROR");
		$finish;
	end

endmodule
